FILE: src/b64d_pkg.sv
// Shared types, constants and the character decode function for the base64 stream decoder.
package b64d_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int BYTE_COUNT_WIDTH = 16;

  localparam logic [7:0] CH_PLUS       = 8'd43;
  localparam logic [7:0] CH_SLASH      = 8'd47;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_DIGIT_0    = 8'd48;
  localparam logic [7:0] CH_DIGIT_9    = 8'd57;
  localparam logic [7:0] CH_UPPER_A    = 8'd65;
  localparam logic [7:0] CH_UPPER_Z    = 8'd90;
  localparam logic [7:0] CH_LOWER_A    = 8'd97;
  localparam logic [7:0] CH_LOWER_Z    = 8'd122;
  localparam logic [7:0] CH_PAD        = 8'd61;
  localparam logic [7:0] CH_PRINT_LO   = 8'h21;
  localparam logic [7:0] CH_PRINT_HI   = 8'h7E;

  localparam logic [5:0] SEXTET_62 = 6'd62;
  localparam logic [5:0] SEXTET_63 = 6'd63;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [7:0]                  data_byte;
    logic                        is_final;
    logic                        decode_error;
    logic [BYTE_COUNT_WIDTH-1:0] byte_count;
  } result_item_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Classified character, as handed from the front to the back.
  typedef struct packed {
    logic       end_of_text;
    logic       printable;
    logic       is_pad;
    logic       sextet_ok;
    logic [5:0] sextet;
  } class_item_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_FOURTH
  } phase_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch, input logic url);
    sextet_t    s;
    logic [7:0] c62;
    logic [7:0] c63;
    logic [7:0] t;
    c62 = url ? CH_MINUS : CH_PLUS;
    c63 = url ? CH_UNDERSCORE : CH_SLASH;
    s.ok = 1'b1;
    s.val = 6'd0;
    t = 8'd0;
    if (ch == c62) begin
      s.val = SEXTET_62;
    end else if (ch == c63) begin
      s.val = SEXTET_63;
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      t = ch + 8'd4;
      s.val = t[5:0];
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      t = ch - CH_UPPER_A;
      s.val = t[5:0];
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      t = ch - 8'd71;
      s.val = t[5:0];
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

FILE: src/b64d_front.sv
// Front stage: accepts characters, holds the alphabet register and classifies each item.
module b64d_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  b64d_pkg::char_item_t  char_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  output logic                  cls_valid,
  input  logic                  cls_ready,
  output b64d_pkg::class_item_t cls_item
);

  logic                  url_alphabet;
  logic                  stage_valid;
  b64d_pkg::class_item_t stage_item;
  b64d_pkg::class_item_t classified;
  b64d_pkg::sextet_t     sx;
  logic                  load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
    end else if (cfg_valid) begin
      url_alphabet <= cfg_data;
    end
  end

  always_comb begin
    sx = b64d_pkg::sextet_of(char_item.char_code, url_alphabet);
    classified.end_of_text = char_item.end_of_text;
    classified.printable   = (char_item.char_code >= b64d_pkg::CH_PRINT_LO) &&
                             (char_item.char_code <= b64d_pkg::CH_PRINT_HI);
    classified.is_pad      = (char_item.char_code == b64d_pkg::CH_PAD);
    classified.sextet_ok   = sx.ok;
    classified.sextet      = sx.val;
  end

  // The stage register frees up whenever the queue takes its item.
  assign load       = !stage_valid || cls_ready;
  assign char_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && char_valid) begin
      stage_item <= classified;
    end
  end

  assign cls_valid = stage_valid;
  assign cls_item  = stage_item;

endmodule

FILE: src/b64d_queue.sv
// Two-entry queue between the classifying front and the decoding back.
module b64d_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  b64d_pkg::class_item_t push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output b64d_pkg::class_item_t pop_item
);

  b64d_pkg::class_item_t slots [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: src/b64d_back.sv
// Back stage: group state machine, byte assembly, byte counter and result register.
module b64d_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cls_valid,
  output logic                   cls_ready,
  input  b64d_pkg::class_item_t  cls_item,
  output logic                   res_valid,
  input  logic                   res_stall,
  output b64d_pkg::result_item_t res_item
);

  localparam int WIDE_WIDTH = b64d_pkg::COUNT_WIDTH + b64d_pkg::BYTE_COUNT_WIDTH;

  b64d_pkg::phase_t                  phase;
  b64d_pkg::phase_t                  phase_next;
  logic [5:0]                        prior_sextet;
  logic [5:0]                        prior_sextet_next;
  logic                              stopped_ok;
  logic                              stopped_ok_next;
  logic                              failed;
  logic                              failed_next;
  logic [b64d_pkg::COUNT_WIDTH-1:0]  bytes_out;
  logic [b64d_pkg::COUNT_WIDTH-1:0]  bytes_out_next;
  logic                              take;
  logic                              emit;
  b64d_pkg::result_item_t            result;
  logic [WIDE_WIDTH-1:0]             wide_count;
  logic                              halted;
  logic                              good;

  assign take      = cls_valid && (!res_valid || !res_stall);
  assign cls_ready = !res_valid || !res_stall;
  assign halted    = stopped_ok || failed;
  assign good      = cls_item.sextet_ok;

  // Next state of the group sequencer and stream status.
  always_comb begin
    phase_next        = phase;
    prior_sextet_next = prior_sextet;
    stopped_ok_next   = stopped_ok;
    failed_next       = failed;
    bytes_out_next    = bytes_out;
    if (cls_item.end_of_text) begin
      phase_next        = b64d_pkg::PH_FIRST;
      prior_sextet_next = 6'd0;
      stopped_ok_next   = 1'b0;
      failed_next       = 1'b0;
      bytes_out_next    = '0;
    end else if (!halted) begin
      unique case (phase)
        b64d_pkg::PH_FIRST: begin
          if (!cls_item.printable) begin
            stopped_ok_next = 1'b1;
          end else if (!good) begin
            failed_next = 1'b1;
          end else begin
            prior_sextet_next = cls_item.sextet;
            phase_next        = b64d_pkg::PH_SECOND;
          end
        end
        b64d_pkg::PH_SECOND: begin
          if (!good) begin
            failed_next = 1'b1;
          end else begin
            prior_sextet_next = cls_item.sextet;
            phase_next        = b64d_pkg::PH_THIRD;
          end
        end
        b64d_pkg::PH_THIRD: begin
          if (cls_item.is_pad) begin
            stopped_ok_next = 1'b1;
          end else if (!good) begin
            failed_next = 1'b1;
          end else begin
            prior_sextet_next = cls_item.sextet;
            phase_next        = b64d_pkg::PH_FOURTH;
          end
        end
        b64d_pkg::PH_FOURTH: begin
          if (cls_item.is_pad) begin
            stopped_ok_next = 1'b1;
          end else if (!good) begin
            failed_next = 1'b1;
          end else begin
            prior_sextet_next = cls_item.sextet;
            phase_next        = b64d_pkg::PH_FIRST;
          end
        end
        default: begin
          phase_next = b64d_pkg::PH_FIRST;
        end
      endcase
      if (emit && bytes_out != {b64d_pkg::COUNT_WIDTH{1'b1}}) begin
        bytes_out_next = bytes_out + 1'b1;
      end
    end
  end

  // Result for the item at the head of the queue.
  always_comb begin
    emit                = 1'b0;
    result.data_byte    = 8'd0;
    result.is_final     = 1'b0;
    result.decode_error = 1'b0;
    result.byte_count   = '0;
    wide_count          = {{b64d_pkg::BYTE_COUNT_WIDTH{1'b0}}, bytes_out};
    if (cls_item.end_of_text) begin
      emit                = 1'b1;
      result.is_final     = 1'b1;
      result.decode_error = failed || (!stopped_ok && phase == b64d_pkg::PH_SECOND);
      if (wide_count > WIDE_WIDTH'(16'hFFFF)) begin
        result.byte_count = 16'hFFFF;
      end else begin
        result.byte_count = wide_count[b64d_pkg::BYTE_COUNT_WIDTH-1:0];
      end
    end else if (!halted && good) begin
      unique case (phase)
        b64d_pkg::PH_FIRST: begin
          emit = 1'b0;
        end
        b64d_pkg::PH_SECOND: begin
          emit             = 1'b1;
          result.data_byte = {prior_sextet, cls_item.sextet[5:4]};
        end
        b64d_pkg::PH_THIRD: begin
          emit             = !cls_item.is_pad;
          result.data_byte = {prior_sextet[3:0], cls_item.sextet[5:2]};
        end
        b64d_pkg::PH_FOURTH: begin
          emit             = !cls_item.is_pad;
          result.data_byte = {prior_sextet[1:0], cls_item.sextet};
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (!emit) begin
        result.data_byte = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= b64d_pkg::PH_FIRST;
      prior_sextet <= 6'd0;
      stopped_ok   <= 1'b0;
      failed       <= 1'b0;
      bytes_out    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      prior_sextet <= prior_sextet_next;
      stopped_ok   <= stopped_ok_next;
      failed       <= failed_next;
      bytes_out    <= bytes_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cls_ready) begin
      res_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_item <= result;
    end
  end

endmodule

FILE: src/base64_stream_decoder.sv
// Top level of the streaming base64 decoder: front, queue and back wired together.
//
// Usage:
//   char channel: one text character per item (char_valid, char_stall,
//     char_item). An item with end_of_text set closes the stream; its
//     char_code is ignored.
//   res channel: at most one result item per input item (res_valid,
//     res_stall, res_item). Data bytes come on the second, third and
//     fourth character of each group; the end item yields a final item
//     with the status and the saturating byte count.
//   cfg channel: cfg_data sets the alphabet (0 standard, 1 URL-safe).
//     cfg_ready is always high; write only while the block is idle.
// Timing: one item per cycle sustained while res_stall is low. The classify
//   register loads at the accepting edge; the item then passes through the
//   two-entry queue into the result register, which drives res_valid.
// Reset: rst clears the stream state, the queue and the alphabet select.
//   After each end item the stream state clears again for the next text.
// Stall: when res_stall holds the result register, the queue fills, then
//   the front register holds and char_stall rises; nothing is dropped.
module base64_stream_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  b64d_pkg::char_item_t   char_item,
  output logic                   res_valid,
  input  logic                   res_stall,
  output b64d_pkg::result_item_t res_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data
);

  // Classified items from the front into the queue.
  logic                  front_valid;
  logic                  front_ready;
  b64d_pkg::class_item_t front_item;

  // Queue head into the back.
  logic                  head_valid;
  logic                  head_ready;
  b64d_pkg::class_item_t head_item;

  // Classify each character and track the alphabet register.
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cls_valid  (front_valid),
    .cls_ready  (front_ready),
    .cls_item   (front_item)
  );

  // Decouple the front from a stalled back.
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  // Advance the group state and build the result items.
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (head_valid),
    .cls_ready (head_ready),
    .cls_item  (head_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule
